@@ rtl/wms_pkg.sv @@
// Package for the weighted minhash sampler: shared constants, types,
// command and status words, and the elaboration-time root table.
// Depends on nothing; used by every other file in rtl but wms_ram and wms_checker.
package wms_pkg;

  localparam int unsigned Dims        = 256;
  localparam int unsigned MaxFeatures = 65536;
  localparam int unsigned LogFrac     = 24;
  localparam int unsigned DivSteps    = 48;
  localparam int unsigned ScoreW      = 48;
  localparam int unsigned EntryW      = 96;

  localparam logic [1:0] SelU1 = 2'd0;
  localparam logic [1:0] SelU2 = 2'd1;
  localparam logic [1:0] SelX  = 2'd2;
  localparam logic [1:0] SelW  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE      = 5'd0,
    CMD_LOAD      = 5'd1,
    CMD_READ      = 5'd2,
    CMD_LOG_INIT  = 5'd3,
    CMD_LOG_STEP  = 5'd4,
    CMD_DIV_INIT1 = 5'd5,
    CMD_DIV_STEP  = 5'd6,
    CMD_TFIX      = 5'd7,
    CMD_CMP_MUL   = 5'd8,
    CMD_CMP_FIX   = 5'd9,
    CMD_E_MUL1    = 5'd10,
    CMD_E_MUL2    = 5'd11,
    CMD_E_SUB     = 5'd12,
    CMD_POW_STEP  = 5'd13,
    CMD_Y         = 5'd14,
    CMD_SC_MUL    = 5'd15,
    CMD_DIV_INIT2 = 5'd16,
    CMD_UPDATE    = 5'd17
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] sel;
    logic [5:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic consider;
    logic dim_ok;
    logic last;
    logic y_zero;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [15:0]       feature;
    logic [31:0]       value;
  } entry_t;

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] nn;
    r     = '0;
    nn    = n;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > nn) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (nn >= r + bit_v) begin
          nn = nn - (r + bit_v);
          r  = (r >> 1) + bit_v;
        end else begin
          r = r >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return r;
  endfunction

  // Entry k holds the Q1.31 value of 2 to the power 2^-(k+1).
  function automatic logic [LogFrac*32-1:0] root_table();
    logic [LogFrac*32-1:0] tab;
    logic [63:0]           c;
    tab = '0;
    c   = 64'h1_0000_0000;
    for (int k = 0; k < LogFrac; k++) begin
      c = isqrt64(c << 31);
      tab[k*32 +: 32] = c[31:0];
    end
    return tab;
  endfunction

endpackage

@@ rtl/wms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wms_ctrl.sv @@
// Sequencer of the weighted minhash sampler: steps the datapath through
// logarithms, divisions, power and update. Depends on wms_pkg.
module wms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wms_pkg::stat_t  stat_i,
  output wms_pkg::cmd_t   cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_READ      = 17'h00002,
    S_LOG_INIT  = 17'h00004,
    S_LOG_STEP  = 17'h00008,
    S_DIV_INIT1 = 17'h00010,
    S_DIV       = 17'h00020,
    S_TFIX      = 17'h00040,
    S_CMP_MUL   = 17'h00080,
    S_CMP_FIX   = 17'h00100,
    S_E_MUL1    = 17'h00200,
    S_E_MUL2    = 17'h00400,
    S_E_SUB     = 17'h00800,
    S_POW       = 17'h01000,
    S_Y         = 17'h02000,
    S_SC_MUL    = 17'h04000,
    S_DIV_INIT2 = 17'h08000,
    S_UPDATE    = 17'h10000
  } state_e;

  localparam logic [5:0] LastLog = 6'(wms_pkg::LogFrac - 1);
  localparam logic [5:0] LastDiv = 6'(wms_pkg::DivSteps - 1);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] op_q, op_d;
  logic       phase_q, phase_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    phase_d   = phase_q;
    cmd_o.op  = wms_pkg::CMD_NONE;
    cmd_o.sel = op_q;
    cmd_o.cnt = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = wms_pkg::CMD_LOAD;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        cmd_o.op = wms_pkg::CMD_READ;
        op_d     = wms_pkg::SelU1;
        state_d  = (stat_i.consider && stat_i.dim_ok) ? S_LOG_INIT : S_UPDATE;
      end
      S_LOG_INIT: begin
        cmd_o.op = wms_pkg::CMD_LOG_INIT;
        cnt_d    = '0;
        state_d  = S_LOG_STEP;
      end
      S_LOG_STEP: begin
        cmd_o.op = wms_pkg::CMD_LOG_STEP;
        if (cnt_q == LastLog) begin
          if (op_q == wms_pkg::SelW) begin
            state_d = S_DIV_INIT1;
          end else begin
            op_d    = op_q + 2'd1;
            state_d = S_LOG_INIT;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DIV_INIT1: begin
        cmd_o.op = wms_pkg::CMD_DIV_INIT1;
        cnt_d    = '0;
        phase_d  = 1'b0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = wms_pkg::CMD_DIV_STEP;
        if (cnt_q == LastDiv) begin
          state_d = phase_q ? S_UPDATE : S_TFIX;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_TFIX: begin
        cmd_o.op = wms_pkg::CMD_TFIX;
        state_d  = S_CMP_MUL;
      end
      S_CMP_MUL: begin
        cmd_o.op = wms_pkg::CMD_CMP_MUL;
        state_d  = S_CMP_FIX;
      end
      S_CMP_FIX: begin
        cmd_o.op = wms_pkg::CMD_CMP_FIX;
        state_d  = S_E_MUL1;
      end
      S_E_MUL1: begin
        cmd_o.op = wms_pkg::CMD_E_MUL1;
        state_d  = S_E_MUL2;
      end
      S_E_MUL2: begin
        cmd_o.op = wms_pkg::CMD_E_MUL2;
        state_d  = S_E_SUB;
      end
      S_E_SUB: begin
        cmd_o.op = wms_pkg::CMD_E_SUB;
        cnt_d    = '0;
        state_d  = S_POW;
      end
      S_POW: begin
        cmd_o.op = wms_pkg::CMD_POW_STEP;
        if (cnt_q == LastLog) begin
          state_d = S_Y;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_Y: begin
        cmd_o.op = wms_pkg::CMD_Y;
        state_d  = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.op = wms_pkg::CMD_SC_MUL;
        state_d  = S_DIV_INIT2;
      end
      S_DIV_INIT2: begin
        cmd_o.op = wms_pkg::CMD_DIV_INIT2;
        cnt_d    = '0;
        phase_d  = 1'b1;
        state_d  = stat_i.y_zero ? S_UPDATE : S_DIV;
      end
      S_UPDATE: begin
        if (!(stat_i.last && stat_i.dim_ok) || stat_i.out_free) begin
          cmd_o.op = wms_pkg::CMD_UPDATE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      op_q    <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/wms_dp.sv @@
// Datapath of the weighted minhash sampler: operand registers, shared
// multiplier, shift-subtract divider, entry RAM, seen bits and output word.
// Depends on wms_pkg and wms_ram.
module wms_dp #(
  parameter int unsigned DIMS = wms_pkg::Dims
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      dim_index_i,
  input  logic [15:0]     feature_id_i,
  input  logic [31:0]     weight_i,
  input  logic [31:0]     beta_rand_i,
  input  logic [31:0]     x_rand_i,
  input  logic [31:0]     u1_rand_i,
  input  logic [31:0]     u2_rand_i,
  input  logic            last_feature_i,
  input  wms_pkg::cmd_t   cmd_i,
  output wms_pkg::stat_t  stat_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      out_dim_o,
  output logic [15:0]     min_feature_o,
  output logic [31:0]     min_value_o,
  output logic            found_o
);

  localparam int unsigned AW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [wms_pkg::LogFrac*32-1:0] RootTab = wms_pkg::root_table();

  logic [7:0]  dim_q;
  logic [15:0] fid_q;
  logic [31:0] w_q, beta_q, x_q, u1_q, u2_q;
  logic        last_q;

  logic [31:0] m_q;
  logic [23:0] frac_q;
  logic [4:0]  lead_q;
  logic [29:0] lu1_q, lu2_q, lx_q, lw_q;

  logic [47:0] dvd_q;
  logic [31:0] rem_q, dsr_q;
  logic        neg_q;
  logic [31:0] t_q;
  logic [30:0] r0_q;
  logic [63:0] prod_q;
  logic [31:0] ceil_q, e_q, p_q, y_q;

  logic [DIMS-1:0] seen_q;
  logic            out_valid_q;
  logic [7:0]      out_dim_q;
  logic [15:0]     out_feat_q;
  logic [31:0]     out_val_q;
  logic            out_found_q;

  logic [31:0] log_src, norm;
  logic [4:0]  lead;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq_sh;
  logic        sq_bit;
  logic [31:0] m_next;
  logic [23:0] frac_next;
  logic [28:0] log_val;
  logic [30:0] g;
  logic [32:0] div_r;
  logic        div_ge;
  logic [29:0] lw_abs;
  logic [4:0]  bidx;
  logic [31:0] ck;
  logic [7:0]  ip;
  logic [8:0]  shamt;
  logic [31:0] y_calc;
  logic [AW-1:0] addr;
  logic [wms_pkg::EntryW-1:0] rdata;
  wms_pkg::entry_t entry, wentry;
  logic [wms_pkg::ScoreW-1:0] score;
  logic        seen_cur, better, we, out_load;
  logic [31:0] qa;

  assign addr = AW'(dim_q);
  assign g    = 31'(lu1_q) + 31'(lu2_q);

  always_comb begin
    unique case (cmd_i.sel)
      wms_pkg::SelU1: log_src = u1_q;
      wms_pkg::SelU2: log_src = u2_q;
      wms_pkg::SelX:  log_src = x_q;
      wms_pkg::SelW:  log_src = w_q;
      default:        log_src = w_q;
    endcase
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (log_src[i]) lead = 5'(i);
    end
    norm = log_src << (5'd31 - lead);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      wms_pkg::CMD_LOG_STEP: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      wms_pkg::CMD_CMP_MUL: begin
        mul_a = {1'b0, g};
        mul_b = 32'd0 - beta_q;
      end
      wms_pkg::CMD_E_MUL1: begin
        mul_a = beta_q;
        mul_b = {1'b0, g};
      end
      wms_pkg::CMD_E_MUL2: begin
        mul_a = t_q;
        mul_b = {1'b0, g};
      end
      wms_pkg::CMD_POW_STEP: begin
        mul_a = p_q;
        mul_b = ck;
      end
      wms_pkg::CMD_SC_MUL: begin
        mul_a = {2'b00, lx_q};
        mul_b = u1_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = 64'(mul_a) * 64'(mul_b);
  assign sq_sh     = mul_p[63:31];
  assign sq_bit    = sq_sh[32];
  assign m_next    = sq_bit ? sq_sh[32:1] : sq_sh[31:0];
  assign frac_next = {frac_q[22:0], sq_bit};
  assign log_val   = {lead_q, frac_next};

  assign div_r  = {rem_q, dvd_q[47]};
  assign div_ge = (div_r >= {1'b0, dsr_q});
  assign lw_abs = lw_q[29] ? (30'd0 - lw_q) : lw_q;
  assign qa     = dvd_q[31:0];

  assign bidx = 5'(wms_pkg::LogFrac - 1) - cmd_i.cnt[4:0];
  assign ck   = RootTab[{cmd_i.cnt[4:0], 5'b00000} +: 32];

  always_comb begin
    ip     = e_q[31:24];
    shamt  = 9'sd15 - {ip[7], ip};
    if ($signed(ip) >= 8'sd15) begin
      y_calc = p_q;
    end else if ($signed(shamt) >= 9'sd32) begin
      y_calc = '0;
    end else begin
      y_calc = p_q >> shamt[4:0];
    end
  end

  wms_ram #(
    .WIDTH(wms_pkg::EntryW),
    .DEPTH(DIMS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wentry),
    .re_i   (cmd_i.op == wms_pkg::CMD_READ),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  assign stat_o.consider = (w_q != 32'd0) && (32'(fid_q) < wms_pkg::MaxFeatures);
  assign stat_o.dim_ok   = (32'(dim_q) < DIMS);
  assign stat_o.last     = last_q;
  assign stat_o.y_zero   = (y_q == 32'd0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    entry          = wms_pkg::entry_t'(rdata);
    score          = stat_o.y_zero ? '1 : dvd_q;
    seen_cur       = seen_q[addr];
    better         = stat_o.consider && stat_o.dim_ok &&
                     (!seen_cur || (score < entry.score));
    wentry.score   = score;
    wentry.feature = fid_q;
    wentry.value   = y_q;
    we             = (cmd_i.op == wms_pkg::CMD_UPDATE) && better;
    out_load       = (cmd_i.op == wms_pkg::CMD_UPDATE) && stat_o.dim_ok && last_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      wms_pkg::CMD_LOAD: begin
        dim_q  <= dim_index_i;
        fid_q  <= feature_id_i;
        w_q    <= weight_i;
        beta_q <= (beta_rand_i == 32'd0) ? 32'd1 : beta_rand_i;
        x_q    <= (x_rand_i == 32'd0) ? 32'd1 : x_rand_i;
        u1_q   <= (u1_rand_i == 32'd0) ? 32'd1 : u1_rand_i;
        u2_q   <= (u2_rand_i == 32'd0) ? 32'd1 : u2_rand_i;
        last_q <= last_feature_i;
      end
      wms_pkg::CMD_LOG_INIT: begin
        m_q    <= norm;
        lead_q <= lead;
        frac_q <= '0;
      end
      wms_pkg::CMD_LOG_STEP: begin
        m_q    <= m_next;
        frac_q <= frac_next;
        if (cmd_i.cnt == 6'(wms_pkg::LogFrac - 1)) begin
          unique case (cmd_i.sel)
            wms_pkg::SelU1: lu1_q <= 30'h2000_0000 - {1'b0, log_val};
            wms_pkg::SelU2: lu2_q <= 30'h2000_0000 - {1'b0, log_val};
            wms_pkg::SelX:  lx_q  <= 30'h2000_0000 - {1'b0, log_val};
            wms_pkg::SelW:  lw_q  <= {1'b0, log_val} - 30'h1000_0000;
            default:        lw_q  <= {1'b0, log_val} - 30'h1000_0000;
          endcase
        end
      end
      wms_pkg::CMD_DIV_INIT1: begin
        dvd_q <= 48'(lw_abs);
        rem_q <= '0;
        dsr_q <= {1'b0, g};
        neg_q <= lw_q[29];
      end
      wms_pkg::CMD_DIV_STEP: begin
        rem_q <= div_ge ? 32'(div_r - {1'b0, dsr_q}) : div_r[31:0];
        dvd_q <= {dvd_q[46:0], div_ge};
      end
      wms_pkg::CMD_TFIX: begin
        if (neg_q && (rem_q != 32'd0)) begin
          t_q  <= ~qa;
          r0_q <= g - rem_q[30:0];
        end else if (neg_q) begin
          t_q  <= 32'd0 - qa;
          r0_q <= '0;
        end else begin
          t_q  <= qa;
          r0_q <= rem_q[30:0];
        end
      end
      wms_pkg::CMD_CMP_MUL: begin
        prod_q <= mul_p;
      end
      wms_pkg::CMD_CMP_FIX: begin
        if ({1'b0, r0_q, 32'h0} >= prod_q) t_q <= t_q + 32'd1;
      end
      wms_pkg::CMD_E_MUL1: begin
        prod_q <= mul_p;
      end
      wms_pkg::CMD_E_MUL2: begin
        ceil_q <= prod_q[63:32] + {31'd0, |prod_q[31:0]};
        prod_q <= mul_p;
      end
      wms_pkg::CMD_E_SUB: begin
        e_q <= prod_q[31:0] - ceil_q;
        p_q <= 32'h8000_0000;
      end
      wms_pkg::CMD_POW_STEP: begin
        if (e_q[bidx]) p_q <= mul_p[62:31];
      end
      wms_pkg::CMD_Y: begin
        y_q <= y_calc;
      end
      wms_pkg::CMD_SC_MUL: begin
        prod_q <= mul_p;
      end
      wms_pkg::CMD_DIV_INIT2: begin
        dvd_q <= {2'b00, prod_q[61:16]};
        rem_q <= '0;
        dsr_q <= y_q;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_dim_q   <= dim_q;
      out_found_q <= seen_cur | better;
      if (better) begin
        out_feat_q <= fid_q;
        out_val_q  <= y_q;
      end else if (seen_cur) begin
        out_feat_q <= entry.feature;
        out_val_q  <= entry.value;
      end else begin
        out_feat_q <= '0;
        out_val_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((cmd_i.op == wms_pkg::CMD_UPDATE) && stat_o.dim_ok) begin
        if (last_q) begin
          seen_q[addr] <= 1'b0;
        end else if (better) begin
          seen_q[addr] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_dim_o     = out_dim_q;
  assign min_feature_o = out_feat_q;
  assign min_value_o   = out_val_q;
  assign found_o       = out_found_q;

endmodule

@@ rtl/weighted_minhash_sampler_top.sv @@
// Weighted minhash sampler top level. A word with positive weight runs the whole datapath
// before the next word is taken (the second division is skipped when y is zero), a word
// with zero weight or an unused dimension goes straight to its update; a fingerprint word
// appears the cycle after its update. One shared 32x32 multiplier does 4 logarithms
// of 24 squarings and 24 power steps; a one-bit-per-cycle divider runs twice.
// Reset clears the controller, the per-dimension seen bits and the output valid.
module weighted_minhash_sampler_top #(
  parameter int unsigned DIMS = wms_pkg::Dims
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  dim_index_i,
  input  logic [15:0] feature_id_i,
  input  logic [31:0] weight_i,
  input  logic [31:0] beta_rand_i,
  input  logic [31:0] x_rand_i,
  input  logic [31:0] u1_rand_i,
  input  logic [31:0] u2_rand_i,
  input  logic        last_feature_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_dim_o,
  output logic [15:0] min_feature_o,
  output logic [31:0] min_value_o,
  output logic        found_o
);

  wms_pkg::cmd_t  cmd;
  wms_pkg::stat_t stat;

  wms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wms_dp #(
    .DIMS(DIMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dim_index_i   (dim_index_i),
    .feature_id_i  (feature_id_i),
    .weight_i      (weight_i),
    .beta_rand_i   (beta_rand_i),
    .x_rand_i      (x_rand_i),
    .u1_rand_i     (u1_rand_i),
    .u2_rand_i     (u2_rand_i),
    .last_feature_i(last_feature_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_dim_o     (out_dim_o),
    .min_feature_o (min_feature_o),
    .min_value_o   (min_value_o),
    .found_o       (found_o)
  );

endmodule

@@ rtl/wms_checker.sv @@
// Port-level checks for the weighted minhash sampler, bound to the top level.
// Depends only on the top level's ports.
module wms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_dim_o,
  input logic [15:0] min_feature_o,
  input logic [31:0] min_value_o,
  input logic        found_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_dim_o) &&
    $stable(min_feature_o) && $stable(min_value_o) && $stable(found_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> min_feature_o == 16'd0 && min_value_o == 32'd0)
    else $error("empty dimension reports a nonzero fingerprint");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word appeared without a word in work");

endmodule

bind weighted_minhash_sampler_top wms_checker u_wms_checker (.*);
